// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL of the packed element sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define PESD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property checked at every edge, reset included.
`define PESD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PESD_ASSERT(label, clk, rstn, prop, msg)
`define PESD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/pesd_pkg.sv =====
// Types and constants shared by the packed element sorter modules.
`default_nettype none
package pesd_pkg;
    localparam int WORD_W   = 64;
    localparam int NUM_LANES = 16;
    localparam int ELEM_W   = 8;
    localparam int RANK_W   = 4;
    localparam int BYTE_CNT = 8;

    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_NIBBLE = 1'b1;

    localparam logic [NUM_LANES-1:0] BYTE_ACTIVE   = 16'h00FF;
    localparam logic [NUM_LANES-1:0] NIBBLE_ACTIVE = 16'hFFFF;

    typedef logic [NUM_LANES-1:0][ELEM_W-1:0] elem_arr_t;
    typedef logic [NUM_LANES-1:0][RANK_W-1:0] rank_arr_t;

    // Everything the merge stage needs from the lanes.
    typedef struct packed {
        logic                 mode;
        logic [NUM_LANES-1:0] active;
        elem_arr_t            elem;
        rank_arr_t            rank;
    } rank_stage_t;
endpackage
`default_nettype wire

// ===== rtl/packed_element_sort_descending.sv =====
// Sixteen rank lanes then one merge stage, both registered: an accepted word is held in
// the lane stage, then on m_tdata. Throughput: one word per cycle unless stalled.
// A stalled output holds its word while one more word waits in the lane stage.
// Reset (aresetn low, synchronous) empties both stages and sets byte mode.
// element_mode is sampled with each word and travels down the pipeline.
`default_nettype none
`include "assert_macros.svh"
module packed_element_sort_descending
    import pesd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,  // element_mode
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [WORD_W-1:0] s_tdata,      // [63:0] word_in
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [WORD_W-1:0] m_tdata       // [63:0] sorted_word
);
    logic                 mode_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    rank_stage_t          st1_reg;
    rank_stage_t          st1_next;
    logic [WORD_W-1:0]    out_reg;
    logic [WORD_W-1:0]    merged;
    logic                 ready2;
    logic                 ready1;
    logic [NUM_LANES-1:0] active_in;
    elem_arr_t            elem_in;
    rank_arr_t            rank_in;

    assign ready2   = !v2_reg || m_tready;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign m_tvalid = v2_reg;
    assign m_tdata  = out_reg;

    assign active_in = (mode_reg == MODE_NIBBLE) ? NIBBLE_ACTIVE : BYTE_ACTIVE;

    // Split the word into elements, zero-extending nibbles.
    always_comb begin
        elem_in = '0;
        if (mode_reg == MODE_NIBBLE) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                elem_in[i] = {{(ELEM_W/2){1'b0}}, s_tdata[(ELEM_W/2)*i +: ELEM_W/2]};
            end
        end else begin
            for (int i = 0; i < BYTE_CNT; i++) begin
                elem_in[i] = s_tdata[ELEM_W*i +: ELEM_W];
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pesd_lane u_lane (
            .elem     (elem_in),
            .active   (active_in),
            .lane_idx (RANK_W'(g)),
            .rank     (rank_in[g])
        );
    end

    always_comb begin
        st1_next.mode   = mode_reg;
        st1_next.active = active_in;
        st1_next.elem   = elem_in;
        st1_next.rank   = rank_in;
    end

    pesd_merge u_merge (
        .stage       (st1_reg),
        .packed_word (merged)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BYTE;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Payload registers load only when their stage advances.
    always_ff @(posedge aclk) begin
        if (ready1 && s_tvalid) begin
            st1_reg <= st1_next;
        end
        if (ready2 && v1_reg) begin
            out_reg <= merged;
        end
    end

    `PESD_ASSERT(a_in_to_lane, aclk, aresetn,
        s_tvalid && s_tready |=> v1_reg, "accepted transaction lost before lane stage")
    `PESD_ASSERT(a_lane_hold, aclk, aresetn,
        v1_reg && !ready2 |=> v1_reg && $stable(st1_reg), "lane stage changed under stall")
    `PESD_ASSERT(a_stall_cause, aclk, aresetn,
        !s_tready |-> v1_reg && m_tvalid && !m_tready, "input stalled with room in pipeline")
    `PESD_ASSERT(a_drain, aclk, aresetn,
        m_tvalid && m_tready && !v1_reg |=> !m_tvalid, "result repeated after transfer")
    `PESD_ASSERT(a_lane_to_out, aclk, aresetn,
        v1_reg && ready2 |=> m_tvalid, "lane result not moved to output")
    `PESD_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_tvalid && !v1_reg, "pipeline not empty after reset")
endmodule
`default_nettype wire

// ===== rtl/pesd_lane.sv =====
// One sorting lane: rank of its element among all active elements.
`default_nettype none
module pesd_lane
    import pesd_pkg::*;
(
    input  wire elem_arr_t            elem,
    input  wire logic [NUM_LANES-1:0] active,
    input  wire logic [RANK_W-1:0]    lane_idx,
    output logic      [RANK_W-1:0]    rank
);
    logic [ELEM_W-1:0] own;
    logic [RANK_W:0]   cnt;

    assign own = elem[lane_idx];

    // Count larger elements, and equal ones in lower lanes to break ties.
    always_comb begin
        cnt = '0;
        for (int j = 0; j < NUM_LANES; j++) begin
            if (active[j] && (RANK_W'(j) != lane_idx)) begin
                if ((elem[j] > own) || ((elem[j] == own) && (RANK_W'(j) < lane_idx))) begin
                    cnt = cnt + (RANK_W+1)'(1);
                end
            end
        end
    end

    assign rank = cnt[RANK_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/pesd_merge.sv =====
// Merge stage: place each element at the slot its rank selects and repack.
`default_nettype none
module pesd_merge
    import pesd_pkg::*;
(
    input  wire rank_stage_t       stage,
    output logic [WORD_W-1:0]      packed_word
);
    elem_arr_t sorted;

    // Each active rank is unique, so an OR of the matching lanes picks one element.
    always_comb begin
        sorted = '0;
        for (int r = 0; r < NUM_LANES; r++) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                if (stage.active[i] && (stage.rank[i] == RANK_W'(r))) begin
                    sorted[r] = sorted[r] | stage.elem[i];
                end
            end
        end
    end

    // Rank zero is the largest and lands in the most significant slot.
    always_comb begin
        packed_word = '0;
        case (stage.mode)
            MODE_BYTE: begin
                for (int r = 0; r < BYTE_CNT; r++) begin
                    packed_word[ELEM_W*(BYTE_CNT-1-r) +: ELEM_W] = sorted[r];
                end
            end
            MODE_NIBBLE: begin
                for (int r = 0; r < NUM_LANES; r++) begin
                    packed_word[(ELEM_W/2)*(NUM_LANES-1-r) +: ELEM_W/2] =
                        sorted[r][ELEM_W/2-1:0];
                end
            end
            default: begin
                packed_word = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== tb/packed_element_sort_descending_tb.sv =====
// Self-checking testbench for the packed byte and nibble descending sorter.
`timescale 1ns / 100ps
module packed_element_sort_descending_tb;
    import pesd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 134;

    typedef struct packed {
        logic              mode;
        logic              has_sorted;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] sorted;
    } dir_row_t;

    // Rows without a typed result are checked against the predictor.
    localparam dir_row_t DIR_ROWS [18] = '{
        '{MODE_BYTE,   1'b1, 64'h0000000000000000, 64'h0000000000000000},
        '{MODE_BYTE,   1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF},
        '{MODE_BYTE,   1'b1, 64'h0123456789ABCDEF, 64'hEFCDAB8967452301},
        '{MODE_BYTE,   1'b1, 64'h8000000000000001, 64'h8001000000000000},
        '{MODE_BYTE,   1'b1, 64'h0102030405060708, 64'h0807060504030201},
        '{MODE_BYTE,   1'b1, 64'hA5A5A5A5A5A5A5A5, 64'hA5A5A5A5A5A5A5A5},
        '{MODE_BYTE,   1'b1, 64'h00000000000000FF, 64'hFF00000000000000},
        '{MODE_BYTE,   1'b0, 64'hDEADBEEFCAFEF00D, 64'h0},
        '{MODE_NIBBLE, 1'b1, 64'h0000000000000000, 64'h0000000000000000},
        '{MODE_NIBBLE, 1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF},
        '{MODE_NIBBLE, 1'b1, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210},
        '{MODE_NIBBLE, 1'b1, 64'h7777777777777777, 64'h7777777777777777},
        '{MODE_NIBBLE, 1'b1, 64'h000000000000000F, 64'hF000000000000000},
        '{MODE_NIBBLE, 1'b1, 64'h1000000000000000, 64'h1000000000000000},
        '{MODE_NIBBLE, 1'b1, 64'h0000000000000001, 64'h1000000000000000},
        '{MODE_NIBBLE, 1'b0, 64'hDEADBEEFCAFEF00D, 64'h0},
        '{MODE_BYTE,   1'b1, 64'hFEDCBA9876543210, 64'hFEDCBA9876543210},
        '{MODE_BYTE,   1'b0, 64'h5555AAAA5555AAAA, 64'h0}
    };

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic              cfg_wr_data = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [WORD_W-1:0] m_tdata;

    logic              cur_mode    = MODE_BYTE;
    logic [WORD_W-1:0] want_sorted = '0;
    logic [WORD_W-1:0] sorted_expected [$];
    logic [WORD_W-1:0] oldest_sorted;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                error_count   = 0;
    int                results_checked = 0;
    int                byte_words    = 0;
    int                nibble_words  = 0;
    int                stall_cycles  = 0;

    packed_element_sort_descending u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Counting sort: emit element values from the largest down, MSB first.
    function automatic logic [WORD_W-1:0] sort_desc_word(input logic mode,
                                                         input logic [WORD_W-1:0] word);
        int unsigned       tally [256];
        int unsigned       width;
        int unsigned       slot;
        int                val;
        logic [WORD_W-1:0] sorted;
        width  = (mode == MODE_NIBBLE) ? 4 : 8;
        sorted = '0;
        foreach (tally[v]) tally[v] = 0;
        for (int k = 0; k < WORD_W / width; k++) begin
            tally[(word >> (k * width)) & ((64'd1 << width) - 1)]++;
        end
        slot = WORD_W / width;
        for (val = (1 << width) - 1; val >= 0; val--) begin
            repeat (tally[val]) begin
                slot--;
                sorted |= 64'(val) << (slot * width);
            end
        end
        return sorted;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Present one word and hold it until the transaction completes.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] sorted);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= word;
        want_sorted <= sorted;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (cur_mode == MODE_NIBBLE) nibble_words++;
        else byte_words++;
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sorted_expected.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_mode     = mode;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sorted_expected.push_back(want_sorted);
            end
            if (m_tvalid && m_tready) begin
                if (sorted_expected.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", m_tdata));
                end else begin
                    oldest_sorted = sorted_expected.pop_front();
                    results_checked++;
                    if (m_tdata !== oldest_sorted) begin
                        report_mismatch($sformatf("sorted_word %h, expected %h",
                                                  m_tdata, oldest_sorted));
                    end
                end
            end
        end
    end

    // Abort when neither side completes a transaction for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", sorted_expected.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] emask;
        logic [7:0]        elem_a;
        logic [7:0]        elem_b;
        int unsigned       width;
        int unsigned       pick;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        set_mode(MODE_BYTE);
        for (int r = 0; r < $size(DIR_ROWS); r++) begin
            if (DIR_ROWS[r].mode != cur_mode) set_mode(DIR_ROWS[r].mode);
            send_word(DIR_ROWS[r].word, DIR_ROWS[r].has_sorted ? DIR_ROWS[r].sorted
                                        : sort_desc_word(cur_mode, DIR_ROWS[r].word));
        end

        // Each idle profile runs once in byte mode and once in nibble mode.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            set_mode((phase % 2) ? MODE_NIBBLE : MODE_BYTE);
            width = (cur_mode == MODE_NIBBLE) ? 4 : 8;
            emask = (64'd1 << width) - 1;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i == PHASE_WORDS / 2) drain_results();
                pick = $urandom_range(0, 4);
                case (pick)
                    0: word = {$urandom(), $urandom()};
                    1, 2: begin
                        // Few distinct values, or all elements equal.
                        elem_a = 8'($urandom());
                        elem_b = (pick == 2) ? elem_a : 8'($urandom());
                        word   = '0;
                        for (int k = 0; k < WORD_W / width; k++) begin
                            word |= (64'($urandom_range(0, 1) ? elem_a : elem_b) & emask)
                                    << (k * width);
                        end
                    end
                    3: word = sort_desc_word(cur_mode, {$urandom(), $urandom()});
                    default: word = {$urandom(), $urandom()} & {$urandom(), $urandom()}
                                    & {$urandom(), $urandom()};
                endcase
                send_word(word, sort_desc_word(cur_mode, word));
            end
        end

        drain_results();
        repeat (5) @(negedge aclk);
        if (sorted_expected.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", sorted_expected.size()));
        end
        $display("Checked %0d results: %0d directed rows, %0d byte-mode and %0d nibble-mode words",
                 results_checked, $size(DIR_ROWS), byte_words, nibble_words);
        $display("Covered sender-heavy, receiver-heavy and no idling, with a drain in each phase");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
